// ===== rtl/core/lru_key_value_store_defines.svh =====
// Assertion macros for the checker file of the LRU key-value store.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef LRU_KEY_VALUE_STORE_DEFINES_SVH
`define LRU_KEY_VALUE_STORE_DEFINES_SVH

// Same-cycle implication.
`define LKV_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LKV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared constants for the LRU key-value store: default sizes, field widths
// and request kind codes.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 32;

    localparam int KIND_BITS = 2;
    localparam int CAP_BITS  = 5;
    localparam int OCC_BITS  = 5;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic [KIND_BITS-1:0] KIND_SET = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_GET = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_DEL = 2'd2;
    // spare code: no operation
    localparam logic [KIND_BITS-1:0] KIND_NOP = 2'd3;

endpackage

// ===== rtl/core/lru_key_value_store.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_store
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// One request at a time: the next item is taken only after the result of
// the last has gone into the output register. The key scan does most of the
// work: the key memory has one read port, so the slots are compared one per
// cycle by a single comparator, then a short sequencer applies at most two
// list operations (unlink / touch) to the recency ranks.
// The finished result sits in an output register, so a new item is accepted
// while the previous result waits to be taken. Capacity may be written only
// while the block is idle; zero acts as one, above ENTRIES acts as ENTRIES.
module lru_key_value_store
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CAP_BITS-1:0]   cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [KIND_BITS-1:0]  kind,
    input  logic [KEY_BITS-1:0]   key,
    input  logic [VALUE_BITS-1:0] value,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  hit,
    output logic [VALUE_BITS-1:0] read_value,
    output logic                  evicted,
    output logic [KEY_BITS-1:0]   evicted_key,
    output logic [OCC_BITS-1:0]   occupancy
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int SCN_W = IDX_W + 1;
    localparam int CMP_W = ((CNT_W > CAP_BITS) ? CNT_W : CAP_BITS) + 1;

    localparam logic [SCN_W-1:0] SCAN_END = SCN_W'(ENTRIES);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCAN   = 7'b0000010,
        ST_DECIDE = 7'b0000100,
        ST_OP1    = 7'b0001000,
        ST_OP2    = 7'b0010000,
        ST_DONE   = 7'b0100000,
        ST_SPARE  = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_TOUCH  = 2'd1,
        OP_UNLINK = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [IDX_W-1:0]  slot;
        logic [IDX_W-1:0]  thr;     // on unlink or relink, ranks above this move down by one
        logic              relink;  // touch of a slot that is already linked
        logic              wr;      // touch also writes key and value
    } op_t;

    state_t state_reg, state_next;

    logic [CAP_BITS-1:0]   capacity_reg;

    logic [KIND_BITS-1:0]  kind_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;

    logic [SCN_W-1:0]      cnt_reg;
    logic                  pipe_vld_reg;
    logic [IDX_W-1:0]      pipe_idx_reg;

    logic                  found_reg;
    logic [IDX_W-1:0]      s_idx_reg;
    logic [IDX_W-1:0]      s_rank_reg;
    logic                  has_lr0_reg;
    logic [IDX_W-1:0]      lr0_reg;
    logic [IDX_W-1:0]      lr1_reg;
    logic                  free_found_reg;
    logic [IDX_W-1:0]      free_reg;

    op_t                   op1_reg, op1_next;
    op_t                   op2_reg, op2_next;
    op_t                   op_act;
    logic                  ev_reg, ev_next;
    logic                  get_hit_reg, get_hit_next;
    logic [IDX_W-1:0]      ev_slot;

    logic [KEY_BITS-1:0]   evk_hold_reg;
    logic [VALUE_BITS-1:0] rdv_hold_reg;

    logic [ENTRIES-1:0]    valid_reg;
    logic [IDX_W-1:0]      rank_reg [ENTRIES];
    logic [CNT_W-1:0]      count_reg;

    logic [KEY_BITS-1:0]   key_mem [ENTRIES];
    logic [VALUE_BITS-1:0] val_mem [ENTRIES];
    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;
    logic [IDX_W-1:0]      key_raddr;

    logic                  out_valid_reg;
    logic                  hit_reg;
    logic [VALUE_BITS-1:0] read_value_reg;
    logic                  evicted_reg;
    logic [KEY_BITS-1:0]   evicted_key_reg;
    logic [OCC_BITS-1:0]   occupancy_reg;

    logic                  in_acc;
    logic                  out_load;

    logic [CMP_W-1:0]      cap_w;
    logic [CMP_W-1:0]      ent_w;
    logic [CMP_W-1:0]      cap_eff;
    logic [CMP_W-1:0]      count_w;
    logic [IDX_W-1:0]      target;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == SCAN_END)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: state_next = ST_OP1;
            ST_OP1:    state_next = ST_OP2;
            ST_OP2:    state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            capacity_reg <= CAP_RESET;
            cnt_reg      <= '0;
            pipe_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
            if (in_acc)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_SCAN && cnt_reg != SCAN_END)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            pipe_vld_reg <= (state_reg == ST_SCAN) && (cnt_reg != SCAN_END);
        end
    end

    // ------------------------------------------------------------------
    // Request capture and slot scan (one slot compared per cycle)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        pipe_idx_reg <= cnt_reg[IDX_W-1:0];
        if (in_acc)
        begin
            kind_reg       <= kind;
            key_reg        <= key;
            value_reg      <= value;
            found_reg      <= 1'b0;
            has_lr0_reg    <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (state_reg == ST_SCAN && pipe_vld_reg)
        begin
            if (valid_reg[pipe_idx_reg])
            begin
                if (rd_key_reg == key_reg && !found_reg)
                begin
                    found_reg  <= 1'b1;
                    s_idx_reg  <= pipe_idx_reg;
                    s_rank_reg <= rank_reg[pipe_idx_reg];
                end
                if (rank_reg[pipe_idx_reg] == '0)
                begin
                    has_lr0_reg <= 1'b1;
                    lr0_reg     <= pipe_idx_reg;
                end
                if (rank_reg[pipe_idx_reg] == IDX_W'(1))
                begin
                    lr1_reg <= pipe_idx_reg;
                end
            end
            else if (!free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_reg       <= pipe_idx_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Decide the list operations for this request
    // ------------------------------------------------------------------
    assign cap_w   = CMP_W'(capacity_reg);
    assign ent_w   = CMP_W'(ENTRIES);
    assign count_w = CMP_W'(count_reg);

    always_comb
    begin
        if (cap_w == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_w > ent_w)
        begin
            cap_eff = ent_w;
        end
        else
        begin
            cap_eff = cap_w;
        end
    end

    // A miss that evicts reuses the lowest free slot, which may be the victim.
    assign target = (free_found_reg && free_reg < lr0_reg) ? free_reg : lr0_reg;

    always_comb
    begin
        op1_next     = '0;
        op2_next     = '0;
        ev_next      = 1'b0;
        get_hit_next = 1'b0;
        ev_slot      = lr0_reg;
        unique case (kind_reg)
            KIND_SET:
            begin
                if (found_reg)
                begin
                    op1_next = '{OP_TOUCH, s_idx_reg, s_rank_reg, 1'b1, 1'b1};
                    if (count_w > cap_eff)
                    begin
                        // after the touch the oldest is the old second oldest
                        // when the touched slot was the oldest
                        ev_next  = 1'b1;
                        ev_slot  = (s_rank_reg == '0) ? lr1_reg : lr0_reg;
                        op2_next = '{OP_UNLINK, ev_slot, '0, 1'b0, 1'b0};
                    end
                end
                else
                begin
                    if ((count_w + 1'b1) > cap_eff && has_lr0_reg)
                    begin
                        ev_next  = 1'b1;
                        op1_next = '{OP_UNLINK, lr0_reg, '0, 1'b0, 1'b0};
                        op2_next = '{OP_TOUCH, target, '0, 1'b0, 1'b1};
                    end
                    else if (free_found_reg)
                    begin
                        op2_next = '{OP_TOUCH, free_reg, '0, 1'b0, 1'b1};
                    end
                end
            end
            KIND_GET:
            begin
                if (found_reg)
                begin
                    get_hit_next = 1'b1;
                    op1_next     = '{OP_TOUCH, s_idx_reg, s_rank_reg, 1'b1, 1'b0};
                end
            end
            KIND_DEL:
            begin
                if (found_reg)
                begin
                    op1_next = '{OP_UNLINK, s_idx_reg, s_rank_reg, 1'b0, 1'b0};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op1_reg     <= '0;
            op2_reg     <= '0;
            ev_reg      <= 1'b0;
            get_hit_reg <= 1'b0;
        end
        else if (state_reg == ST_DECIDE)
        begin
            op1_reg     <= op1_next;
            op2_reg     <= op2_next;
            ev_reg      <= ev_next;
            get_hit_reg <= get_hit_next;
        end
    end

    always_comb
    begin
        op_act = '0;
        if (state_reg == ST_OP1)
        begin
            op_act = op1_reg;
        end
        else if (state_reg == ST_OP2)
        begin
            op_act = op2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Recency ranks, valid bits and count
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (op_act.kind != OP_NONE)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (valid_reg[i] && rank_reg[i] > op_act.thr &&
                    (op_act.kind == OP_UNLINK || op_act.relink))
                begin
                    rank_reg[i] <= rank_reg[i] - 1'b1;
                end
            end
            if (op_act.kind == OP_UNLINK)
            begin
                valid_reg[op_act.slot] <= 1'b0;
                rank_reg[op_act.slot]  <= '0;
                if (count_reg != '0)
                begin
                    count_reg <= count_reg - 1'b1;
                end
            end
            else if (op_act.relink)
            begin
                rank_reg[op_act.slot] <= IDX_W'(count_reg - 1'b1);
            end
            else
            begin
                valid_reg[op_act.slot] <= 1'b1;
                rank_reg[op_act.slot]  <= IDX_W'(count_reg);
                count_reg              <= count_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Key and value memories
    // ------------------------------------------------------------------
    assign key_raddr = (state_reg == ST_SCAN) ? cnt_reg[IDX_W-1:0] : ev_slot;

    always_ff @(posedge clk)
    begin
        if (op_act.kind == OP_TOUCH && op_act.wr)
        begin
            key_mem[op_act.slot] <= key_reg;
            val_mem[op_act.slot] <= value_reg;
        end
        rd_key_reg <= key_mem[key_raddr];
        rd_val_reg <= val_mem[s_idx_reg];
    end

    // ------------------------------------------------------------------
    // Result
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OP1)
        begin
            evk_hold_reg <= ev_reg ? rd_key_reg : '0;
            rdv_hold_reg <= get_hit_reg ? rd_val_reg : '0;
        end
        if (out_load)
        begin
            hit_reg         <= found_reg && (kind_reg != KIND_NOP);
            read_value_reg  <= rdv_hold_reg;
            evicted_reg     <= ev_reg;
            evicted_key_reg <= evk_hold_reg;
            occupancy_reg   <= OCC_BITS'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;
    assign occupancy   = occupancy_reg;

endmodule

// ===== rtl/core/lkv_checker.sv =====
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks for the LRU key-value store, bound to the top level.
// ----------------------------------------------------------------------------
`include "lru_key_value_store_defines.svh"

module lkv_checker
    import lkv_pkg::*;
#(
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic                  hit,
    input logic [VALUE_BITS-1:0] read_value,
    input logic                  evicted,
    input logic [KEY_BITS-1:0]   evicted_key,
    input logic [OCC_BITS-1:0]   occupancy
);

    // a held result must stay valid and keep its evicted key
    `LKV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(evicted_key), "result changed while stalled")

    // one item at a time: busy right after an accept
    `LKV_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted item while busy")

    `LKV_ASSERT_IMPL(a_miss_reads_zero, out_valid && !hit, read_value == '0, "read_value nonzero on miss")

    `LKV_ASSERT_IMPL(a_no_evict_key_zero, out_valid && !evicted, evicted_key == '0, "evicted_key set without eviction")

    // an eviction only happens on a set, which leaves at least one entry
    `LKV_ASSERT_IMPL(a_evict_keeps_entry, out_valid && evicted, occupancy != '0, "store empty after eviction")

endmodule

bind lru_key_value_store lkv_checker #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
) u_lkv_checker (.*);
